// File: rtl/assert_macros.svh
// assertion macros used by the toroidal collision cell
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcc assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcc assertion failed");

`endif

// File: rtl/tcc_pkg.sv
// constants, codes and shift tables for the toroidal collision block
package tcc_pkg;

  localparam int COORD_BITS  = 24;
  localparam int WRAP_BITS   = 23;
  localparam int RAD_BITS    = 16;
  localparam int RSUM_BITS   = RAD_BITS + 1;
  localparam int RSQ_BITS    = 2 * RSUM_BITS;
  localparam int DIST_BITS   = 50;
  localparam int HALF_BITS   = DIST_BITS / 2;
  localparam int IMAGE_COUNT = 9;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic signed [1:0] SHIFT_X [IMAGE_COUNT] =
    '{2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1};
  localparam logic signed [1:0] SHIFT_Y [IMAGE_COUNT] =
    '{2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

  typedef enum logic [0:0] {
    REG_WRAP_WIDTH  = 1'b0,
    REG_WRAP_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int CFG_INDEX_BITS = 1;

endpackage

// File: rtl/tcc_ifs.sv
// valid/ready channels for circle pair items and collision result items
interface tcc_pair_if #(
  parameter int COORD_BITS = tcc_pkg::COORD_BITS
);
  logic                               valid;
  logic                               ready;
  logic signed [COORD_BITS-1:0]       ax;
  logic signed [COORD_BITS-1:0]       ay;
  logic [tcc_pkg::RAD_BITS-1:0]       radius_a;
  logic signed [COORD_BITS-1:0]       bx;
  logic signed [COORD_BITS-1:0]       by;
  logic [tcc_pkg::RAD_BITS-1:0]       radius_b;

  modport source (output valid, ax, ay, radius_a, bx, by, radius_b, input ready);
  modport sink   (input valid, ax, ay, radius_a, bx, by, radius_b, output ready);
endinterface

interface tcc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          collides;
  logic [tcc_pkg::DIST_BITS-1:0] least_sq_distance;

  modport source (output valid, collides, least_sq_distance, input ready);
  modport sink   (input valid, collides, least_sq_distance, output ready);
endinterface

// File: rtl/toroidal_circle_collision.sv
// top level: toroidal circle collision test over nine wrapped images
//
//   channel   dir  handshake          payload
//   pair      in   valid/ready        ax, ay, radius_a, bx, by, radius_b
//   result    out  valid/ready        collides, least_sq_distance
//   cfg       in   cfg_wr_en          cfg_index, cfg_data
//
// one item per cycle while result.ready is high; each item passes through the cells in order
// nine cells of three register stages each, one cell per wrapped image
// rst clears all stage valid bits and both wrap registers
// ready ripples back stage by stage, so empty stages keep taking items
// while a finished result waits at the output
module toroidal_circle_collision #(
  parameter int COORD_BITS = tcc_pkg::COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [tcc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tcc_pkg::WRAP_BITS-1:0]         cfg_data,
  tcc_pair_if.sink                              pair,
  tcc_result_if.source                          result
);

  localparam int N = tcc_pkg::IMAGE_COUNT;

  logic [tcc_pkg::WRAP_BITS-1:0] wrap_width, wrap_height;
  logic [tcc_pkg::RSUM_BITS-1:0] rsum;

  logic                          ch_valid [N+1];
  logic                          ch_ready [N+1];
  logic signed [COORD_BITS-1:0]  ch_ax    [N+1];
  logic signed [COORD_BITS-1:0]  ch_ay    [N+1];
  logic signed [COORD_BITS-1:0]  ch_bx    [N+1];
  logic signed [COORD_BITS-1:0]  ch_by    [N+1];
  logic [tcc_pkg::RSQ_BITS-1:0]  ch_rsq   [N+1];
  logic [tcc_pkg::DIST_BITS-1:0] ch_best  [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width  <= '0;
      wrap_height <= '0;
    end else if (cfg_wr_en) begin
      case (tcc_pkg::cfg_reg_t'(cfg_index))
        tcc_pkg::REG_WRAP_WIDTH:  wrap_width  <= cfg_data;
        tcc_pkg::REG_WRAP_HEIGHT: wrap_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rsum        = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
  assign ch_valid[0] = pair.valid;
  assign pair.ready  = ch_ready[0];
  assign ch_ax[0]    = pair.ax;
  assign ch_ay[0]    = pair.ay;
  assign ch_bx[0]    = pair.bx;
  assign ch_by[0]    = pair.by;
  assign ch_rsq[0]   = tcc_pkg::RSQ_BITS'(rsum) * tcc_pkg::RSQ_BITS'(rsum);
  assign ch_best[0]  = tcc_pkg::DIST_MAX;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tcc_cell #(
      .COORD_BITS (COORD_BITS),
      .IMG        (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wrap_width  (wrap_width),
      .wrap_height (wrap_height),
      .src_valid   (ch_valid[i]),
      .src_ready   (ch_ready[i]),
      .src_ax      (ch_ax[i]),
      .src_ay      (ch_ay[i]),
      .src_bx      (ch_bx[i]),
      .src_by      (ch_by[i]),
      .src_rsq     (ch_rsq[i]),
      .src_best    (ch_best[i]),
      .dst_valid   (ch_valid[i+1]),
      .dst_ready   (ch_ready[i+1]),
      .dst_ax      (ch_ax[i+1]),
      .dst_ay      (ch_ay[i+1]),
      .dst_bx      (ch_bx[i+1]),
      .dst_by      (ch_by[i+1]),
      .dst_rsq     (ch_rsq[i+1]),
      .dst_best    (ch_best[i+1])
    );
  end

  assign result.valid             = ch_valid[N];
  assign ch_ready[N]              = result.ready;
  assign result.least_sq_distance = ch_best[N];
  assign result.collides          = tcc_pkg::DIST_BITS'(ch_rsq[N]) >= ch_best[N];

endmodule

// File: rtl/tcc_cell.sv
// one image cell: offset, square, and fold into the running least distance
`include "assert_macros.svh"

module tcc_cell #(
  parameter int COORD_BITS = tcc_pkg::COORD_BITS,
  parameter int IMG        = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tcc_pkg::WRAP_BITS-1:0]     wrap_width,
  input  logic [tcc_pkg::WRAP_BITS-1:0]     wrap_height,
  input  logic                              src_valid,
  output logic                              src_ready,
  input  logic signed [COORD_BITS-1:0]      src_ax,
  input  logic signed [COORD_BITS-1:0]      src_ay,
  input  logic signed [COORD_BITS-1:0]      src_bx,
  input  logic signed [COORD_BITS-1:0]      src_by,
  input  logic [tcc_pkg::RSQ_BITS-1:0]      src_rsq,
  input  logic [tcc_pkg::DIST_BITS-1:0]     src_best,
  output logic                              dst_valid,
  input  logic                              dst_ready,
  output logic signed [COORD_BITS-1:0]      dst_ax,
  output logic signed [COORD_BITS-1:0]      dst_ay,
  output logic signed [COORD_BITS-1:0]      dst_bx,
  output logic signed [COORD_BITS-1:0]      dst_by,
  output logic [tcc_pkg::RSQ_BITS-1:0]      dst_rsq,
  output logic [tcc_pkg::DIST_BITS-1:0]     dst_best
);

  localparam int HALF = tcc_pkg::HALF_BITS;
  localparam int DIST = tcc_pkg::DIST_BITS;
  localparam int EXT  = COORD_BITS + HALF + 2;
  localparam logic signed [1:0] SX = tcc_pkg::SHIFT_X[IMG];
  localparam logic signed [1:0] SY = tcc_pkg::SHIFT_Y[IMG];

  logic signed [EXT-1:0] wx, hy, dx, dy;
  logic [EXT-1:0]        absx, absy;

  // stage a: offset differences
  logic                          a_valid, a_ready;
  logic signed [COORD_BITS-1:0]  a_ax, a_ay, a_bx, a_by;
  logic [tcc_pkg::RSQ_BITS-1:0]  a_rsq;
  logic [DIST-1:0]               a_best;
  logic [HALF-1:0]               a_magx, a_magy;
  logic                          a_overx, a_overy;

  // stage b: squares
  logic                          b_valid, b_ready;
  logic signed [COORD_BITS-1:0]  b_ax, b_ay, b_bx, b_by;
  logic [tcc_pkg::RSQ_BITS-1:0]  b_rsq;
  logic [DIST-1:0]               b_best;
  logic [DIST-1:0]               b_sqx, b_sqy;

  // stage c: fold
  logic                          c_valid, c_ready;
  logic signed [COORD_BITS-1:0]  c_ax, c_ay, c_bx, c_by;
  logic [tcc_pkg::RSQ_BITS-1:0]  c_rsq;
  logic [DIST-1:0]               c_best;
  logic [DIST:0]                 sum;
  logic [DIST-1:0]               img_dist, best_next;

  assign c_ready   = !c_valid || dst_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign src_ready = a_ready;

  always_comb begin
    wx = '0;
    hy = '0;
    if (SX == 2'sd1) begin
      wx = EXT'($signed({1'b0, wrap_width}));
    end else if (SX == -2'sd1) begin
      wx = -EXT'($signed({1'b0, wrap_width}));
    end
    if (SY == 2'sd1) begin
      hy = EXT'($signed({1'b0, wrap_height}));
    end else if (SY == -2'sd1) begin
      hy = -EXT'($signed({1'b0, wrap_height}));
    end
    dx   = EXT'(src_ax) + wx - EXT'(src_bx);
    dy   = EXT'(src_ay) + hy - EXT'(src_by);
    absx = dx[EXT-1] ? EXT'(-dx) : EXT'(dx);
    absy = dy[EXT-1] ? EXT'(-dy) : EXT'(dy);
  end

  always_comb begin
    sum       = {1'b0, b_sqx} + {1'b0, b_sqy};
    img_dist  = sum[DIST] ? tcc_pkg::DIST_MAX : sum[DIST-1:0];
    best_next = (img_dist < b_best) ? img_dist : b_best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= src_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ax    <= src_ax;
      a_ay    <= src_ay;
      a_bx    <= src_bx;
      a_by    <= src_by;
      a_rsq   <= src_rsq;
      a_best  <= src_best;
      a_magx  <= absx[HALF-1:0];
      a_magy  <= absy[HALF-1:0];
      a_overx <= |absx[EXT-1:HALF];
      a_overy <= |absy[EXT-1:HALF];
    end
    if (b_ready) begin
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_bx   <= a_bx;
      b_by   <= a_by;
      b_rsq  <= a_rsq;
      b_best <= a_best;
      b_sqx  <= a_overx ? tcc_pkg::DIST_MAX : DIST'(a_magx) * DIST'(a_magx);
      b_sqy  <= a_overy ? tcc_pkg::DIST_MAX : DIST'(a_magy) * DIST'(a_magy);
    end
    if (c_ready) begin
      c_ax   <= b_ax;
      c_ay   <= b_ay;
      c_bx   <= b_bx;
      c_by   <= b_by;
      c_rsq  <= b_rsq;
      c_best <= best_next;
    end
  end

  assign dst_valid = c_valid;
  assign dst_ax    = c_ax;
  assign dst_ay    = c_ay;
  assign dst_bx    = c_bx;
  assign dst_by    = c_by;
  assign dst_rsq   = c_rsq;
  assign dst_best  = c_best;

  `TCC_ASSERT_NEXT(a_best_never_grows, c_ready && b_valid, c_best <= $past(b_best))
  `TCC_ASSERT_NEXT(a_over_saturates, b_ready && a_valid && a_overx, b_sqx == tcc_pkg::DIST_MAX)
  `TCC_ASSERT_NEXT(a_stall_holds, c_valid && !dst_ready, c_valid && $stable(c_best))

endmodule
